@@ src/setd_pkg.sv @@
// ----------------------------------------------------------------------------
// setd_pkg: shared types and constants of the spike extremum detector
// Register indexes, mode codes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package setd_pkg;

  localparam int COUNT_W    = 48;
  localparam int THRESH_W   = 15;
  localparam int HW_W       = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd100;
  localparam logic [HW_W-1:0]     HW_RESET     = 6'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_MODE        = 2'd1,
    REG_HALF_WINDOW = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_MULTI   = 2'd0,
    MODE_NEG     = 2'd1,
    MODE_POS     = 2'd2,
    MODE_BIPOLAR = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;   // sample transfer: write ring, advance counter
    logic scan;   // issue one ring read
    logic eval;   // register polarity of the tested centre
    logic emit;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic too_early;  // window around the centre not yet complete
    logic scan_last;  // the read being issued is the oldest window entry
    logic hit;        // tested centre qualifies
    logic slot_free;  // result register can take a new event
  } status_t;

endpackage

`default_nettype wire

@@ src/setd_if.sv @@
// ----------------------------------------------------------------------------
// setd_if: handshake channels of the spike extremum detector
// Sample input, event output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface setd_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface setd_event_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                             valid;
  logic                             ready;
  logic [setd_pkg::COUNT_W-1:0]     event_time;
  logic                             polarity;
  logic signed [SAMPLE_BITS-1:0]    amplitude;

  modport source (output valid, output event_time, output polarity, output amplitude,
                  input ready);
  modport sink   (input valid, input event_time, input polarity, input amplitude,
                  output ready);
endinterface

interface setd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [setd_pkg::CFG_IDX_W-1:0]  index;
  logic [setd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/setd_ctrl.sv @@
// ----------------------------------------------------------------------------
// setd_ctrl: sequencing of one sample
// Accepts a sample, walks the window reads, evaluates and hands off the event.
// ----------------------------------------------------------------------------
`default_nettype none

module setd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire setd_pkg::status_t status_i,
  output setd_pkg::cmd_t         cmd_o
);

  setd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= setd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      setd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // skip the test until the whole window has arrived
          if (!status_i.too_early) state_d = setd_pkg::ST_SCAN;
        end
      end
      setd_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) state_d = setd_pkg::ST_DRAIN;
      end
      setd_pkg::ST_DRAIN: begin
        state_d = setd_pkg::ST_EVAL;
      end
      setd_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.hit ? setd_pkg::ST_EMIT : setd_pkg::ST_IDLE;
      end
      setd_pkg::ST_EMIT: begin
        // hold until the result register is free
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = setd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = setd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/setd_dp.sv @@
// ----------------------------------------------------------------------------
// setd_dp: sample ring, counters, window scan and extremum test
// Holds the registers, the history memory and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module setd_dp #(
  parameter int MAX_HALF_WINDOW = 32,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire setd_pkg::cmd_t                    cmd_i,
  output setd_pkg::status_t                      status_o,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  wire logic                              cfg_valid_i,
  input  wire logic [setd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [setd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [setd_pkg::COUNT_W-1:0]           out_time_o,
  output logic                                   out_polarity_o,
  output logic signed [SAMPLE_BITS-1:0]          out_amplitude_o
);

  localparam int RingDepth = 2 * MAX_HALF_WINDOW + 1;
  localparam int KW        = $clog2(RingDepth);
  // compare width: covers a full sample span and twice the threshold
  localparam int CW        = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;

  localparam logic [KW-1:0] LastPos = KW'(RingDepth - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SampleMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SampleMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration registers
  logic [setd_pkg::THRESH_W-1:0] threshold_q;
  setd_pkg::mode_e               mode_q;
  logic [setd_pkg::HW_W-1:0]     half_window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= setd_pkg::THRESH_RESET;
      mode_q        <= setd_pkg::MODE_MULTI;
      half_window_q <= setd_pkg::HW_RESET;
    end else if (cfg_valid_i) begin
      unique case (setd_pkg::reg_idx_e'(cfg_index_i))
        setd_pkg::REG_THRESHOLD:   threshold_q   <= cfg_data_i[setd_pkg::THRESH_W-1:0];
        setd_pkg::REG_MODE:        mode_q        <= setd_pkg::mode_e'(cfg_data_i[1:0]);
        setd_pkg::REG_HALF_WINDOW: half_window_q <= cfg_data_i[setd_pkg::HW_W-1:0];
        default: ;
      endcase
    end
  end

  // effective half window: at least one, at most the ring allows
  logic [KW-1:0] w_eff;
  logic [KW-1:0] two_w;

  always_comb begin
    if (half_window_q == '0) begin
      w_eff = KW'(1);
    end else if (32'(half_window_q) > 32'(MAX_HALF_WINDOW)) begin
      w_eff = KW'(MAX_HALF_WINDOW);
    end else begin
      w_eff = KW'(half_window_q);
    end
  end

  assign two_w = KW'({w_eff, 1'b0});

  // sample counter and ring pointers
  logic [setd_pkg::COUNT_W-1:0] count_q;
  logic [setd_pkg::COUNT_W-1:0] centre_n_q;
  logic [KW-1:0]                wr_pos_q;
  logic [KW-1:0]                rd_ptr_q;
  logic [KW-1:0]                k_q;
  logic [KW-1:0]                kd_q;
  logic                         rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      wr_pos_q   <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.scan;
      if (cmd_i.load) begin
        count_q  <= count_q + 1'b1;
        wr_pos_q <= (wr_pos_q == LastPos) ? '0 : wr_pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      centre_n_q <= count_q;
      rd_ptr_q   <= wr_pos_q;
      k_q        <= '0;
    end else if (cmd_i.scan) begin
      // step back one sample per read
      rd_ptr_q <= (rd_ptr_q == '0) ? LastPos : rd_ptr_q - 1'b1;
      k_q      <= k_q + 1'b1;
    end
    kd_q <= k_q;
  end

  // history memory, one write and one registered read port
  logic signed [SAMPLE_BITS-1:0] ring_mem [RingDepth];
  logic signed [SAMPLE_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ring_mem[wr_pos_q] <= sample_i;
    end
    rd_data_q <= ring_mem[rd_ptr_q];
  end

  // window capture
  logic signed [SAMPLE_BITS-1:0] c_q, prev_q, next_q, max_q, min_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      max_q <= SampleMin;
      min_q <= SampleMax;
    end else if (rd_valid_q) begin
      if (rd_data_q > max_q) max_q <= rd_data_q;
      if (rd_data_q < min_q) min_q <= rd_data_q;
      if (kd_q == w_eff)               c_q    <= rd_data_q;
      if (kd_q == w_eff + KW'(1))      prev_q <= rd_data_q;
      if (kd_q == w_eff - KW'(1))      next_q <= rd_data_q;
    end
  end

  // extremum test
  logic signed [CW-1:0] ce, pe, ne, mxe, mne, the, two_the;
  logic neg_on, pos_on, neg_ext, pos_ext, hit, pol;

  always_comb begin
    ce      = CW'(c_q);
    pe      = CW'(prev_q);
    ne      = CW'(next_q);
    mxe     = CW'(max_q);
    mne     = CW'(min_q);
    the     = signed'(CW'(threshold_q));
    two_the = the <<< 1;
    neg_on  = (mode_q != setd_pkg::MODE_POS);
    pos_on  = (mode_q != setd_pkg::MODE_NEG);
    neg_ext = neg_on && (ce < pe) && (ce < ne) && (ce <= -the);
    pos_ext = pos_on && (ce > pe) && (ce > ne) && (ce >= the);
    hit     = 1'b0;
    pol     = 1'b0;
    priority if (neg_ext) begin
      hit = (mode_q != setd_pkg::MODE_MULTI) || ((mxe - ce) >= two_the);
    end else if (pos_ext) begin
      hit = (mode_q != setd_pkg::MODE_MULTI) || ((ce - mne) >= two_the);
      pol = 1'b1;
    end else begin
      hit = 1'b0;
    end
  end

  logic pol_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) pol_q <= pol;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_time_o      <= centre_n_q - setd_pkg::COUNT_W'(w_eff);
      out_polarity_o  <= pol_q;
      out_amplitude_o <= c_q;
    end
  end

  assign status_o.too_early = (count_q < setd_pkg::COUNT_W'(two_w));
  assign status_o.scan_last = (k_q == two_w);
  assign status_o.hit       = hit;
  assign status_o.slot_free = !out_valid_o || out_ready_i;

endmodule

`default_nettype wire

@@ src/spike_extremum_threshold_detector.sv @@
// ----------------------------------------------------------------------------
// spike_extremum_threshold_detector: threshold local-extremum spike detector
// Tests the centre of a sliding window of samples for a qualifying trough or peak.
// ----------------------------------------------------------------------------
// Each sample transfer writes the sample into a history ring and tests the
// centre W samples back (W = half_window clamped to 1..MAX_HALF_WINDOW). While
// fewer than 2W+1 samples have arrived since start or counter wrap, a sample
// is only stored and counted. Otherwise the ring is read through its single
// read port, one entry per cycle over the 2W+1 window entries, then the centre
// is evaluated, and an event waits for the event register to drain; no new
// sample is taken until then. The ring needs no clearing after reset. Register
// writes are taken at any time but must only be issued while the block is
// idle.
`default_nettype none

module spike_extremum_threshold_detector #(
  parameter int MAX_HALF_WINDOW = 32,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  setd_sample_if.sink   sample_i,
  setd_event_if.source  event_o,
  setd_cfg_if.sink      cfg_i
);

  setd_pkg::cmd_t    cmd;
  setd_pkg::status_t status;

  assign cfg_i.ready = 1'b1;

  setd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  setd_dp #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .sample_i        (sample_i.sample),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .out_valid_o     (event_o.valid),
    .out_ready_i     (event_o.ready),
    .out_time_o      (event_o.event_time),
    .out_polarity_o  (event_o.polarity),
    .out_amplitude_o (event_o.amplitude)
  );

  // a tested sample keeps the block from accepting another sample while it scans
  a_busy_after_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load && !status.too_early) |=> !sample_i.ready)
    else $error("sample accepted during window scan");

  // never overwrite an event that has not been transferred
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!event_o.valid || event_o.ready))
    else $error("event register overwritten");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> event_o.valid)
    else $error("loaded event not presented");

  a_emit_only_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !sample_i.ready)
    else $error("event loaded while idle");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: spike extremum threshold detector check
// Walks a short table of samples and register writes, then runs phases of
// spike-shaped random samples under several register settings. Every event
// transfer is compared against an in-bench prediction of troughs and peaks.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_HW         = 32;
  localparam int RING_DEPTH     = 2 * MAX_HW + 1;
  localparam int DRAIN_CYCLES   = 2 * MAX_HW + 40;
  localparam int SETTLE_GUARD   = 100000;
  localparam int HOLD_CYCLES    = 600;
  localparam int TIMEOUT_CYCLES = 3_000_000;
  localparam int NUM_ROWS       = 27;
  localparam int NUM_PHASES     = 9;
  localparam logic [setd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [setd_pkg::COUNT_W-1:0] t;
    logic                         pol;
    logic signed [15:0]           amp;
  } spike_t;

  localparam spike_t NO_SPIKE = '0;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [setd_pkg::CFG_IDX_W-1:0] idx;
    logic [15:0]                    value;
    logic                           typed;
    spike_t                         ev;
  } dir_row_t;

  typedef struct packed {
    logic [setd_pkg::THRESH_W-1:0] thr;
    setd_pkg::mode_e               md;
    logic [setd_pkg::HW_W-1:0]     hw;
    logic [11:0]                   items;
  } phase_t;

  // Rows with typed events are plain extremes at a half window of one.
  dir_row_t dir_rows [0:NUM_ROWS-1] = '{
    '{ROW_WRITE,  setd_pkg::REG_HALF_WINDOW, 16'd0,       1'b0, NO_SPIKE},
    '{ROW_WRITE,  REG_UNUSED,                16'hFFFF,    1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd0,       1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'(-200),   1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd0,       1'b1,
      '{48'd1, 1'b0, 16'(-200)}},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd32767,   1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd0,       1'b1,
      '{48'd3, 1'b1, 16'd32767}},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'(-32768), 1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd0,       1'b1,
      '{48'd5, 1'b0, 16'(-32768)}},
    '{ROW_WRITE,  setd_pkg::REG_MODE,        16'(setd_pkg::MODE_NEG), 1'b0, NO_SPIKE},
    '{ROW_WRITE,  setd_pkg::REG_THRESHOLD,   16'h7FFF,    1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd32767,   1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd0,       1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'(-32768), 1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd0,       1'b1,
      '{48'd9, 1'b0, 16'(-32768)}},
    '{ROW_WRITE,  setd_pkg::REG_MODE,        16'(setd_pkg::MODE_POS), 1'b0, NO_SPIKE},
    '{ROW_WRITE,  setd_pkg::REG_THRESHOLD,   16'd0,       1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd1,       1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd0,       1'b1,
      '{48'd11, 1'b1, 16'd1}},
    '{ROW_WRITE,  setd_pkg::REG_MODE,        16'(setd_pkg::MODE_BIPOLAR), 1'b0, NO_SPIKE},
    '{ROW_WRITE,  setd_pkg::REG_HALF_WINDOW, 16'd2,       1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd5,       1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'(-5),     1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd5,       1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'(-5),     1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd5,       1'b0, NO_SPIKE},
    '{ROW_SAMPLE, setd_pkg::REG_THRESHOLD,   16'd0,       1'b0, NO_SPIKE}
  };

  // Half window 63 saturates; half window 0 is taken as one.
  phase_t phases [0:NUM_PHASES-1] = '{
    '{15'd100,   setd_pkg::MODE_MULTI,   6'd63, 12'd60},
    '{15'd0,     setd_pkg::MODE_BIPOLAR, 6'd1,  12'd220},
    '{15'd32767, setd_pkg::MODE_MULTI,   6'd4,  12'd150},
    '{15'd500,   setd_pkg::MODE_NEG,     6'd8,  12'd220},
    '{15'd300,   setd_pkg::MODE_POS,     6'd3,  12'd220},
    '{15'd200,   setd_pkg::MODE_MULTI,   6'd0,  12'd220},
    '{15'd1000,  setd_pkg::MODE_BIPOLAR, 6'd5,  12'd220},
    '{15'd50,    setd_pkg::MODE_MULTI,   6'd32, 12'd60},
    '{15'd2000,  setd_pkg::MODE_MULTI,   6'd12, 12'd300}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  setd_sample_if #(.SAMPLE_BITS(16)) smp_if ();
  setd_event_if  #(.SAMPLE_BITS(16)) evt_if ();
  setd_cfg_if                        cfg_if ();

  spike_extremum_threshold_detector #(
    .MAX_HALF_WINDOW(MAX_HW),
    .SAMPLE_BITS    (16)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(smp_if),
    .event_o (evt_if),
    .cfg_i   (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Detector copy: history, sample counter and registers.
  logic signed [15:0]            win_hist [RING_DEPTH];
  logic [setd_pkg::COUNT_W-1:0]  smp_count;
  logic [setd_pkg::THRESH_W-1:0] thr_cur;
  setd_pkg::mode_e               mode_cur;
  logic [setd_pkg::HW_W-1:0]     hw_cur;

  spike_t awaited[$];
  int     err_count = 0;
  int     src_idle  = 18;
  int     snk_idle  = 55;
  bit     hold_req  = 1'b0;

  function automatic void add_awaited(spike_t ev);
    awaited = {awaited, ev};
  endfunction

  function automatic int hist_back(int unsigned pos, int unsigned back);
    return win_hist[(pos + RING_DEPTH - back) % RING_DEPTH];
  endfunction

  function automatic int unsigned eff_window(logic [setd_pkg::HW_W-1:0] hw);
    if (hw == 0) return 1;
    if (hw > MAX_HW) return MAX_HW;
    return hw;
  endfunction

  function automatic bit predict_spike(input logic signed [15:0] s, output spike_t ev);
    logic [setd_pkg::COUNT_W-1:0] n;
    int unsigned pos, w, k;
    int c, prv, nxt, ext, th;
    bit hit;
    n = smp_count;
    pos = int'(n % RING_DEPTH);
    win_hist[pos] = s;
    smp_count = n + 1'b1;
    w = eff_window(hw_cur);
    ev = NO_SPIKE;
    hit = 1'b0;
    if (n < 2 * w) return 1'b0;
    c   = hist_back(pos, w);
    prv = hist_back(pos, w + 1);
    nxt = hist_back(pos, w - 1);
    th  = int'(thr_cur);
    if (mode_cur != setd_pkg::MODE_POS && c < prv && c < nxt && c <= -th) begin
      hit = 1'b1;
      ev.pol = 1'b0;
      if (mode_cur == setd_pkg::MODE_MULTI) begin
        ext = c;
        for (k = 0; k <= 2 * w; k++) if (hist_back(pos, k) > ext) ext = hist_back(pos, k);
        hit = (ext - c >= 2 * th);
      end
    end else if (mode_cur != setd_pkg::MODE_NEG && c > prv && c > nxt && c >= th) begin
      hit = 1'b1;
      ev.pol = 1'b1;
      if (mode_cur == setd_pkg::MODE_MULTI) begin
        ext = c;
        for (k = 0; k <= 2 * w; k++) if (hist_back(pos, k) < ext) ext = hist_back(pos, k);
        hit = (c - ext >= 2 * th);
      end
    end
    ev.t = n - setd_pkg::COUNT_W'(w);
    ev.amp = 16'(c);
    return hit;
  endfunction

  task automatic report_miss(string tag, spike_t want, spike_t got);
    err_count++;
    if (err_count <= 10)
      $display("%s: expected t=%0d pol=%0d amp=%0d, got t=%0d pol=%0d amp=%0d", tag,
               want.t, want.pol, want.amp, got.t, got.pol, got.amp);
  endtask

  // Called at a rising edge; returns at the edge of the transfer with valid left high.
  task automatic send_sample(logic [15:0] s, bit typed, spike_t typed_ev);
    spike_t ev;
    bit fired;
    while ($urandom_range(99) < src_idle) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    do @(posedge clk_i); while (!smp_if.ready);
    fired = predict_spike($signed(s), ev);
    if (typed) add_awaited(typed_ev);
    else if (fired) add_awaited(ev);
  endtask

  task automatic write_reg(logic [setd_pkg::CFG_IDX_W-1:0] idx,
                           logic [setd_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      setd_pkg::REG_THRESHOLD:   thr_cur = data[setd_pkg::THRESH_W-1:0];
      setd_pkg::REG_MODE:        mode_cur = setd_pkg::mode_e'(data[1:0]);
      setd_pkg::REG_HALF_WINDOW: hw_cur = data[setd_pkg::HW_W-1:0];
      default: ;
    endcase
  endtask

  // Drop valid, wait for every awaited event, then let the last scan finish.
  task automatic settle_block();
    int guard;
    smp_if.valid <= 1'b0;
    guard = 0;
    while (awaited.size() != 0 && guard < SETTLE_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : event_sink
    int hold_left;
    spike_t want, got;
    hold_left = 0;
    evt_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (evt_if.valid && evt_if.ready) begin
        got = '{evt_if.event_time, evt_if.polarity, evt_if.amplitude};
        if (awaited.size() == 0) begin
          report_miss("event with none awaited", NO_SPIKE, got);
        end else begin
          want = awaited.pop_front();
          if (got !== want) report_miss("event mismatch", want, got);
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        evt_if.ready <= 1'b0;
      end else begin
        evt_if.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  initial begin : stimulus
    int wave_q[$];
    int ph, sent, kind, nz, amp, sgn, v, th;
    int unsigned w;
    rst_ni        = 1'b0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    foreach (win_hist[i]) win_hist[i] = '0;
    smp_count = '0;
    thr_cur   = setd_pkg::THRESH_RESET;
    mode_cur  = setd_pkg::MODE_MULTI;
    hw_cur    = setd_pkg::HW_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        settle_block();
        write_reg(dir_rows[r].idx, dir_rows[r].value);
      end else begin
        send_sample(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].ev);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle_block();
      src_idle = (ph < 3) ? 18 : (ph < 6) ? 55 : 0;
      snk_idle = (ph < 3) ? 55 : (ph < 6) ? 18 : 0;
      // Junk in the upper data bits must be masked off by the block.
      write_reg(setd_pkg::REG_THRESHOLD,   {1'($urandom), phases[ph].thr});
      write_reg(setd_pkg::REG_MODE,        {14'($urandom), 2'(phases[ph].md)});
      write_reg(setd_pkg::REG_HALF_WINDOW, {10'($urandom), phases[ph].hw});
      // Stall events long enough to back the block up into the sample side.
      if (ph == 1) hold_req = 1'b1;
      th = int'(phases[ph].thr);
      w  = eff_window(phases[ph].hw);
      wave_q.delete();
      sent = 0;
      while (sent < int'(phases[ph].items)) begin
        if (wave_q.size() == 0) begin
          kind = $urandom_range(99);
          nz = th / 4 + 1;
          repeat ($urandom_range(1, 2 * w + 3))
            wave_q = {wave_q, int'($urandom_range(0, 2 * nz)) - nz};
          if (kind < 75) begin
            amp = (kind < 10) ? th : th + int'($urandom_range(0, th + 50));
            sgn = $urandom_range(1) ? 1 : -1;
            wave_q = {wave_q, sgn * amp / 2};
            wave_q = {wave_q, sgn * amp};
            // flat tip: not a strict extremum
            if (kind >= 10 && kind < 20) wave_q = {wave_q, sgn * amp};
            wave_q = {wave_q, sgn * amp / 3};
            wave_q = {wave_q, -sgn * amp / 2};
          end else if (kind < 90) begin
            repeat ($urandom_range(1, 4))
              wave_q = {wave_q, int'($urandom_range(0, 65535)) - 32768};
          end
        end
        v = wave_q.pop_front();
        v = (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
        send_sample(16'(v), 1'b0, NO_SPIKE);
        sent++;
      end
    end

    settle_block();
    if (awaited.size() != 0) begin
      $display("%0d awaited events never arrived", awaited.size());
      err_count += awaited.size();
    end
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 10);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
